FILE: sv/enpc_pkg.sv
`default_nettype none
package enpc_pkg;
    localparam int TAPS      = 32;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int SAMPLE_W  = 16;
    localparam int POS_W     = 16;
    localparam int AVG_W     = 16;
    localparam int WSUM_W    = SAMPLE_W + IDX_W;
    localparam int ACC_W     = 2 * SAMPLE_W + IDX_W;
    localparam int CFG_W     = 6;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic CMD_TAP    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic CFG_PEAK_BIN  = 1'b0;
    localparam logic CFG_TAP_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_EMIT
    } t_state;
endpackage
`default_nettype wire

FILE: sv/enpc_in_if.sv
`default_nettype none
interface enpc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [4:0]  tap_index;
    logic [15:0] tap_value;
    logic [15:0] sample_value;
    logic        last;
    modport source (output valid, cmd, tap_index, tap_value, sample_value, last,
                    input ready);
    modport sink (input valid, cmd, tap_index, tap_value, sample_value, last,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/enpc_out_if.sv
`default_nettype none
interface enpc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] average;
    logic [15:0] position;
    logic        last_of_run;
    modport source (output valid, average, position, last_of_run, input ready);
    modport sink (input valid, average, position, last_of_run, output ready);
endinterface
`default_nettype wire

FILE: sv/enpc_cell.sv
`default_nettype none
// One tap position: holds a pulse tap and one waveform sample, passes the
// sample on to the next older cell on every shift.
module enpc_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_shift,
    input  wire logic [enpc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                          i_tap_we,
    input  wire logic [enpc_pkg::SAMPLE_W-1:0] i_tap,
    output logic      [enpc_pkg::SAMPLE_W-1:0] o_sample,
    output logic      [enpc_pkg::SAMPLE_W-1:0] o_tap
);
    logic [enpc_pkg::SAMPLE_W-1:0] r_sample;
    logic [enpc_pkg::SAMPLE_W-1:0] r_tap;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
        if (i_tap_we) begin
            r_tap <= i_tap;
        end
    end

    assign o_sample = r_sample;
    assign o_tap    = r_tap;
endmodule
`default_nettype wire

FILE: sv/enpc_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle. The quotient is known to fit
// in AVG_W bits, so only the low AVG_W steps are run.
module enpc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [enpc_pkg::ACC_W-1:0]  i_dividend,
    input  wire logic [enpc_pkg::WSUM_W-1:0] i_divisor,
    output logic                             o_done,
    output logic      [enpc_pkg::AVG_W-1:0]  o_quot
);
    logic [enpc_pkg::WSUM_W-1:0] r_rem;
    logic [enpc_pkg::AVG_W-1:0]  r_lo;
    logic [enpc_pkg::WSUM_W-1:0] r_div;
    logic [4:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [enpc_pkg::WSUM_W+1:0] diff;
    logic                        ge;
    logic [enpc_pkg::WSUM_W-1:0] n_rem;

    always_comb begin
        diff  = {1'b0, r_rem, r_lo[enpc_pkg::AVG_W-1]} - {2'b0, r_div};
        ge    = ~diff[enpc_pkg::WSUM_W+1];
        n_rem = ge ? diff[enpc_pkg::WSUM_W-1:0]
                   : {r_rem[enpc_pkg::WSUM_W-2:0], r_lo[enpc_pkg::AVG_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(enpc_pkg::AVG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[enpc_pkg::ACC_W-1:enpc_pkg::AVG_W];
            r_lo  <= i_dividend[enpc_pkg::AVG_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[enpc_pkg::AVG_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    // zero weight: no tap was used, the average is zero
    assign o_quot = (r_div == '0) ? '0 : r_lo;
endmodule
`default_nettype wire

FILE: sv/edge_normalized_pulse_convolution_top.sv
`default_nettype none
// Channel  | Dir | Handshake     | Transaction payload
// i_in     | in  | valid / ready | cmd, tap_index, tap_value, sample_value, last
// o_out    | out | valid / ready | average, position, last_of_run
// i_cfg_*  | in  | write enable  | i_cfg_idx (0 peak_bin, 1 tap_count), i_cfg_data
//
// A sample that yields a result runs the tap sweep through the cell row (one
// shared 16x16 multiplier, one tap a cycle, plus a drain step for the
// registered product), then the bit-serial divider, then loads the output
// register. A last sample yields up to peak_bin+1 results.
// Reset is synchronous, active low; it clears control state and sets
// tap_count to 1. Taps and samples are not cleared.
// A stalled output holds the sweep in the emit state; once the final result
// sits in the output register, the next input transaction is accepted.
module edge_normalized_pulse_convolution_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    enpc_in_if.sink                         i_in,
    enpc_out_if.source                      o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [enpc_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int SW = enpc_pkg::SAMPLE_W;

    enpc_pkg::t_state r_state;
    enpc_pkg::t_state n_state;

    logic [enpc_pkg::IDX_W-1:0] r_peak;
    logic [enpc_pkg::CNT_W-1:0] r_tap_count;
    logic [enpc_pkg::POS_W-1:0] r_count;
    logic [enpc_pkg::POS_W-1:0] r_n;
    logic [enpc_pkg::IDX_W-1:0] r_m;
    logic                       r_flush;
    logic [enpc_pkg::CNT_W-1:0] r_j;
    logic [2*SW-1:0]            r_prod;
    logic [enpc_pkg::ACC_W-1:0] r_acc;
    logic [enpc_pkg::WSUM_W-1:0] r_wsum;

    logic                       r_ovalid;
    logic [enpc_pkg::AVG_W-1:0] r_avg;
    logic [enpc_pkg::POS_W-1:0] r_pos;
    logic                       r_olast;

    // cell row
    logic [SW-1:0] cell_sample [enpc_pkg::TAPS];
    logic [SW-1:0] cell_tap    [enpc_pkg::TAPS];
    logic [SW-1:0] chain_in    [enpc_pkg::TAPS];

    logic in_acc;
    logic shift;
    logic emit_go;
    logic div_start;
    logic div_done;
    logic [enpc_pkg::AVG_W-1:0] div_quot;

    logic [enpc_pkg::CNT_W-1:0] taps_used;
    logic [enpc_pkg::IDX_W-1:0] age;
    logic                       use_tap;
    logic [SW-1:0]              sel_tap;
    logic [SW-1:0]              sel_sample;
    logic [enpc_pkg::IDX_W-1:0] m_start;
    logic                       has_result;

    // state machine outputs
    always_comb begin
        i_in.ready = (r_state == enpc_pkg::S_IDLE);
        emit_go    = (r_state == enpc_pkg::S_EMIT) && (!r_ovalid || o_out.ready);
        div_start  = (r_state == enpc_pkg::S_ACC) && (r_j == enpc_pkg::CNT_W'(enpc_pkg::TAPS));
    end

    assign in_acc = i_in.valid && i_in.ready;
    assign shift  = in_acc && (i_in.cmd == enpc_pkg::CMD_SAMPLE);

    always_comb begin
        m_start    = (r_count >= enpc_pkg::POS_W'(r_peak)) ? '0
                   : r_peak - r_count[enpc_pkg::IDX_W-1:0];
        has_result = i_in.last || (r_count >= enpc_pkg::POS_W'(r_peak));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            enpc_pkg::S_IDLE: begin
                if (shift && has_result) begin
                    n_state = enpc_pkg::S_ACC;
                end
            end
            enpc_pkg::S_ACC: begin
                if (div_start) begin
                    n_state = enpc_pkg::S_DIV;
                end
            end
            enpc_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = enpc_pkg::S_EMIT;
                end
            end
            enpc_pkg::S_EMIT: begin
                if (emit_go) begin
                    n_state = (r_flush && r_m != r_peak) ? enpc_pkg::S_ACC
                                                         : enpc_pkg::S_IDLE;
                end
            end
            default: n_state = enpc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= enpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_tap_count <= enpc_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                enpc_pkg::CFG_PEAK_BIN:  r_peak      <= i_cfg_data[enpc_pkg::IDX_W-1:0];
                enpc_pkg::CFG_TAP_COUNT: r_tap_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position counter: saturate, clear after the final sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (shift) begin
            if (i_in.last) begin
                r_count <= '0;
            end else if (r_count != enpc_pkg::POS_MAX) begin
                r_count <= r_count + enpc_pkg::POS_W'(1);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < enpc_pkg::TAPS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign chain_in[g] = i_in.sample_value;
            end else begin : g_link
                assign chain_in[g] = cell_sample[g-1];
            end
            enpc_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (shift),
                .i_sample (chain_in[g]),
                .i_tap_we (in_acc && (i_in.cmd == enpc_pkg::CMD_TAP)
                           && (i_in.tap_index == enpc_pkg::IDX_W'(g))),
                .i_tap    (i_in.tap_value),
                .o_sample (cell_sample[g]),
                .o_tap    (cell_tap[g])
            );
        end
    endgenerate

    // tap sweep: select tap j and the sample it meets for this bin
    always_comb begin
        taps_used  = (r_tap_count > enpc_pkg::CNT_W'(enpc_pkg::TAPS))
                   ? enpc_pkg::CNT_W'(enpc_pkg::TAPS) : r_tap_count;
        age        = r_j[enpc_pkg::IDX_W-1:0] - r_m;
        use_tap    = (r_j < taps_used) && (r_j[enpc_pkg::IDX_W-1:0] >= r_m)
                     && (enpc_pkg::POS_W'(age) <= r_n);
        sel_tap    = cell_tap[r_j[enpc_pkg::IDX_W-1:0]];
        sel_sample = cell_sample[age];
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_n     <= r_count;
            r_m     <= m_start;
            r_flush <= i_in.last;
            r_j     <= '0;
            r_prod  <= '0;
            r_acc   <= '0;
            r_wsum  <= '0;
        end else if (r_state == enpc_pkg::S_ACC && !div_start) begin
            r_j    <= r_j + enpc_pkg::CNT_W'(1);
            r_prod <= use_tap ? sel_tap * sel_sample : '0;
            r_acc  <= r_acc + enpc_pkg::ACC_W'(r_prod);
            r_wsum <= r_wsum + (use_tap ? enpc_pkg::WSUM_W'(sel_tap) : '0);
        end else if (emit_go) begin
            // advance to the next flushed bin
            r_m    <= r_m + enpc_pkg::IDX_W'(1);
            r_j    <= '0;
            r_prod <= '0;
            r_acc  <= '0;
            r_wsum <= '0;
        end
    end

    enpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc + enpc_pkg::ACC_W'(r_prod)),
        .i_divisor  (r_wsum),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_go) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_avg   <= div_quot;
            r_pos   <= r_n + enpc_pkg::POS_W'(r_m) - enpc_pkg::POS_W'(r_peak);
            r_olast <= r_flush && (r_m == r_peak);
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.average     = r_avg;
    assign o_out.position    = r_pos;
    assign o_out.last_of_run = r_olast;
endmodule
`default_nettype wire
